// ===== src/iprtl_pkg.sv =====
// shared types and constants for the ip range table lookup block
// no dependencies; imported by the controller, the datapath and the top level

package iprtl_pkg;

    // default sizes of the table
    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    // fixed field widths of the ports
    localparam int INDEX_W   = 10;
    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 11;
    localparam int OUT_PAY_W = 32;

    // request operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_FIND = 1'b1
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // write the request into the table
        logic start;     // begin a search, issue first probe
        logic step;      // evaluate probe data, issue next probe
        logic cap_hit;   // hold found result with probe payload
        logic cap_miss;  // hold not-found result
        logic out_load;  // move held result into output register
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_zero; // search window is empty
        logic hit;        // probed range holds the key
        logic more;       // window still nonempty after this probe
    } ctrl_status_t;

endpackage

// ===== src/iprtl_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on nothing

module iprtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/iprtl_datapath.sv =====
// search datapath: table rams, count register, search window and result registers
// depends on iprtl_pkg and iprtl_ram

module iprtl_datapath #(
    parameter int TABLE_DEPTH   = iprtl_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH = iprtl_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [iprtl_pkg::COUNT_W-1:0]    cfg_write_data,
    input  logic [iprtl_pkg::INDEX_W-1:0]    entry_index,
    input  logic [iprtl_pkg::ADDR_W-1:0]     range_low,
    input  logic [iprtl_pkg::ADDR_W-1:0]     range_high,
    input  logic [iprtl_pkg::ADDR_W-1:0]     entry_payload,
    input  logic [iprtl_pkg::ADDR_W-1:0]     search_key,
    input  iprtl_pkg::ctrl_cmd_t             cmd,
    output iprtl_pkg::ctrl_status_t          status,
    output logic                             found,
    output logic [iprtl_pkg::OUT_PAY_W-1:0]  result_payload
);

    import iprtl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 2;
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic signed [CW-1:0] ONE = CW'(1);

    logic [COUNT_W-1:0]        entry_count_reg;
    logic [ADDR_W-1:0]         key_reg;
    logic signed [CW-1:0]      left_reg;
    logic signed [CW-1:0]      right_reg;
    logic signed [CW-1:0]      mid_reg;
    logic signed [CW-1:0]      left_next;
    logic signed [CW-1:0]      right_next;
    logic signed [CW-1:0]      mid_next;
    logic                      res_found_reg;
    logic [OUT_PAY_W-1:0]      res_pay_reg;
    logic                      out_found_reg;
    logic [OUT_PAY_W-1:0]      out_pay_reg;

    logic [EW-1:0]             count_ext;
    logic [EW-1:0]             count_clamp;
    logic signed [CW-1:0]      right0;
    logic signed [CW-1:0]      mid0;
    logic signed [CW-1:0]      sum_l;
    logic signed [CW-1:0]      sum_r;
    logic [AW+INDEX_W-1:0]     idx_ext;
    logic                      idx_ok;
    logic [63:0]               wr_pay_ext;
    logic [63:0]               rd_pay_ext;
    logic [AW-1:0]             rd_addr;
    logic [ADDR_W-1:0]         lo_d;
    logic [ADDR_W-1:0]         hi_d;
    logic [PAYLOAD_WIDTH-1:0]  pay_d;
    logic                      key_lt;
    logic                      key_gt;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            entry_count_reg <= cfg_write_data;
        end
    end

    // window bounds for a new search, count clamped to the table depth
    always_comb
    begin
        count_ext = EW'(entry_count_reg);
        if (count_ext > EW'(TABLE_DEPTH))
        begin
            count_clamp = EW'(TABLE_DEPTH);
        end
        else
        begin
            count_clamp = count_ext;
        end
        right0 = $signed(CW'(count_clamp)) - ONE;
        mid0   = right0 >>> 1;
    end

    // load address and range check
    assign idx_ext    = (AW + INDEX_W)'(entry_index);
    assign idx_ok     = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign wr_pay_ext = 64'(entry_payload);

    // probe compare and both candidate windows
    always_comb
    begin
        key_lt = (key_reg < lo_d);
        key_gt = (key_reg > hi_d);
        sum_l  = left_reg + mid_reg - ONE;
        sum_r  = mid_reg + ONE + right_reg;
        if (key_lt)
        begin
            left_next  = left_reg;
            right_next = mid_reg - ONE;
            mid_next   = sum_l >>> 1;
        end
        else
        begin
            left_next  = mid_reg + ONE;
            right_next = right_reg;
            mid_next   = sum_r >>> 1;
        end
    end

    assign status.count_zero = (entry_count_reg == '0);
    assign status.hit        = !key_lt && !key_gt;
    assign status.more       = key_lt ? (left_reg < mid_reg) : (mid_reg < right_reg);

    // next probe address
    assign rd_addr = cmd.start ? mid0[AW-1:0] : mid_next[AW-1:0];

    // table memories
    iprtl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_low_ram (
        .clk     (clk),
        .wr_en   (cmd.load && idx_ok),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (range_low),
        .rd_en   (cmd.start || cmd.step),
        .rd_addr (rd_addr),
        .rd_data (lo_d)
    );

    iprtl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_high_ram (
        .clk     (clk),
        .wr_en   (cmd.load && idx_ok),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (range_high),
        .rd_en   (cmd.start || cmd.step),
        .rd_addr (rd_addr),
        .rd_data (hi_d)
    );

    iprtl_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (cmd.load && idx_ok),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (wr_pay_ext[PAYLOAD_WIDTH-1:0]),
        .rd_en   (cmd.start || cmd.step),
        .rd_addr (rd_addr),
        .rd_data (pay_d)
    );

    assign rd_pay_ext = 64'(pay_d);

    // search window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            mid_reg   <= '0;
        end
        else if (cmd.start)
        begin
            left_reg  <= '0;
            right_reg <= right0;
            mid_reg   <= mid0;
        end
        else if (cmd.step)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            mid_reg   <= mid_next;
        end
    end

    // search key
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= search_key;
        end
    end

    // held result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.cap_hit)
        begin
            res_found_reg <= 1'b1;
            res_pay_reg   <= rd_pay_ext[OUT_PAY_W-1:0];
        end
        else if (cmd.cap_miss)
        begin
            res_found_reg <= 1'b0;
            res_pay_reg   <= '0;
        end
        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_pay_reg   <= res_pay_reg;
        end
    end

    assign found          = out_found_reg;
    assign result_payload = out_pay_reg;

`ifndef ASSERT_OFF
    // window stays nonempty when the search goes on
    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !status.hit && status.more |=> left_reg <= right_reg)
        else $error("search window empty while search continues");

    // probe lies inside the window
    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (mid_reg >= left_reg) && (mid_reg <= right_reg))
        else $error("probe index outside search window");

    // probe lies inside the table
    a_mid_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (mid_reg >= '0) && (mid_reg < CW'(TABLE_DEPTH)))
        else $error("probe index outside table");
`endif

endmodule

// ===== src/iprtl_ctrl.sv =====
// search controller: request acceptance, probe sequencing and output handshake
// depends on iprtl_pkg

module iprtl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    operation,
    output logic                    out_valid,
    input  logic                    out_stall,
    output iprtl_pkg::ctrl_cmd_t    cmd,
    input  iprtl_pkg::ctrl_status_t status
);

    import iprtl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   is_find;
    logic   slot_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign is_find   = (operation == OP_FIND);
    assign slot_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_find)
                begin
                    state_next = status.count_zero ? ST_FINISH : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.hit || !status.more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load     = accept && !is_find;
                cmd.start    = accept && is_find && !status.count_zero;
                cmd.cap_miss = accept && is_find && status.count_zero;
            end
            ST_PROBE:
            begin
                cmd.step     = 1'b1;
                cmd.cap_hit  = status.hit;
                cmd.cap_miss = !status.hit && !status.more;
            end
            ST_FINISH:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // a find on a nonempty table starts probing
    a_find_probes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_find && !status.count_zero |=> state_reg == ST_PROBE)
        else $error("find request did not start a search");

    // a finished result lands in the output register
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && slot_free |=> out_valid && (state_reg == ST_IDLE))
        else $error("finished result not moved to output");

    // a new result only comes from the finish state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside finish state");
`endif

endmodule

// ===== src/ip_range_table_lookup.sv =====
// top level of the ip range table lookup block
// depends on iprtl_pkg, iprtl_ctrl and iprtl_datapath
//
// channel   direction  handshake            payload
// input     in         in_valid/in_stall    operation, entry_index, range_low,
//                                           range_high, entry_payload, search_key
// result    out        out_valid/out_stall  found, result_payload
// config    in         cfg_write_enable     cfg_write_data (entry_count)
//
// a load is written into the table when accepted. a find is accepted, then probes
// the table (up to ceil(log2(entry_count + 1)) probes, 11 for 1024 entries) through the
// registered read port of the table rams, then passes through the finish state.
// reset clears entry_count and the control state; table contents stay undefined
// until loaded, so no clearing pass runs. a result waits in the output register
// while new requests are taken; a find that finishes meanwhile holds until it frees.

module ip_range_table_lookup #(
    parameter int TABLE_DEPTH   = iprtl_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH = iprtl_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [iprtl_pkg::COUNT_W-1:0]    cfg_write_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [iprtl_pkg::INDEX_W-1:0]    entry_index,
    input  logic [iprtl_pkg::ADDR_W-1:0]     range_low,
    input  logic [iprtl_pkg::ADDR_W-1:0]     range_high,
    input  logic [iprtl_pkg::ADDR_W-1:0]     entry_payload,
    input  logic [iprtl_pkg::ADDR_W-1:0]     search_key,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [iprtl_pkg::OUT_PAY_W-1:0]  result_payload
);

    import iprtl_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // controller
    iprtl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath
    iprtl_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .entry_index      (entry_index),
        .range_low        (range_low),
        .range_high       (range_high),
        .entry_payload    (entry_payload),
        .search_key       (search_key),
        .cmd              (cmd),
        .status           (status),
        .found            (found),
        .result_payload   (result_payload)
    );

endmodule
